>>> hw/rtl/sld_pkg.sv
// shared types, constants and codes for the sync/length/checksum deframer
`timescale 1ns / 1ps
package sld_pkg;

  localparam int FRAME_BUFFER_BYTES_DEF = 256;

  localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND  = 8'h55;
  localparam logic [7:0]  VERSION_BYTE = 8'h01;
  localparam logic [15:0] MIN_LENGTH   = 16'd5;
  localparam int          PREFIX_BYTES = 4;

  localparam logic [2:0] ST_GOOD    = 3'd0;
  localparam logic [2:0] ST_SUM_BAD = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_LONG    = 3'd3;
  localparam logic [2:0] ST_VERSION = 3'd4;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] payload_byte;
    logic [7:0] seq_number;
    logic [7:0] module_id;
    logic [7:0] command_id;
    logic [2:0] status;
  } result_t;

endpackage

>>> hw/rtl/sld_if.sv
// channel interfaces: received byte words in, frame result words out
`timescale 1ns / 1ps
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sld_out_if;
  logic       valid;
  logic       ready;
  logic       frame_end;
  logic [7:0] payload_byte;
  logic [7:0] seq_number;
  logic [7:0] module_id;
  logic [7:0] command_id;
  logic [2:0] status;

  modport source (output valid, output frame_end, output payload_byte, output seq_number,
                  output module_id, output command_id, output status, input ready);
  modport sink (input valid, input frame_end, input payload_byte, input seq_number,
                input module_id, input command_id, input status, output ready);
endinterface

>>> hw/rtl/sld_parser.sv
// frame parsing state machine: one byte per cycle, at most one result per byte
`timescale 1ns / 1ps
module sld_parser #(
  parameter int FRAME_BUFFER_BYTES = sld_pkg::FRAME_BUFFER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       rx_byte,
  output logic             res_vld,
  output sld_pkg::result_t res
);
  import sld_pkg::*;

  localparam logic [3:0] P_HUNT   = 4'd0;
  localparam logic [3:0] P_SYNC2  = 4'd1;
  localparam logic [3:0] P_LEN_LO = 4'd2;
  localparam logic [3:0] P_LEN_HI = 4'd3;
  localparam logic [3:0] P_VER    = 4'd4;
  localparam logic [3:0] P_SEQ    = 4'd5;
  localparam logic [3:0] P_MOD    = 4'd6;
  localparam logic [3:0] P_CMD    = 4'd7;
  localparam logic [3:0] P_DATA   = 4'd8;
  localparam logic [3:0] P_CHK    = 4'd9;

  // a length above this overflows the frame buffer
  localparam logic [16:0] LONG_LIMIT = 17'(FRAME_BUFFER_BYTES - PREFIX_BYTES);

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  mod_r, mod_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_full;
  logic [15:0] rem_dec;
  logic [7:0]  sum_add;

  assign len_full = {rx_byte, remaining_r[7:0]};
  assign rem_dec  = remaining_r - 16'd1;
  assign sum_add  = sum_r + rx_byte;

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    sum_nxt       = sum_r;
    seq_nxt       = seq_r;
    mod_nxt       = mod_r;
    cmd_nxt       = cmd_r;
    res_vld       = 1'b0;
    res.frame_end    = 1'b0;
    res.payload_byte = 8'd0;
    res.seq_number   = seq_r;
    res.module_id    = mod_r;
    res.command_id   = cmd_r;
    res.status       = ST_GOOD;
    if (byte_vld) begin
      unique case (phase_r)
        P_HUNT: begin
          if (rx_byte == SYNC_FIRST) phase_nxt = P_SYNC2;
        end
        P_SYNC2: begin
          if (rx_byte == SYNC_SECOND) begin
            seq_nxt   = 8'd0;
            mod_nxt   = 8'd0;
            cmd_nxt   = 8'd0;
            phase_nxt = P_LEN_LO;
          end else begin
            phase_nxt = P_HUNT;
          end
        end
        P_LEN_LO: begin
          remaining_nxt = {8'd0, rx_byte};
          phase_nxt     = P_LEN_HI;
        end
        P_LEN_HI: begin
          remaining_nxt = len_full;
          sum_nxt       = 8'd0;
          if (len_full < MIN_LENGTH) begin
            phase_nxt     = P_HUNT;
            res_vld       = 1'b1;
            res.frame_end = 1'b1;
            res.status    = ST_SHORT;
          end else if ({1'b0, len_full} > LONG_LIMIT) begin
            phase_nxt     = P_HUNT;
            res_vld       = 1'b1;
            res.frame_end = 1'b1;
            res.status    = ST_LONG;
          end else begin
            phase_nxt = P_VER;
          end
        end
        P_VER: begin
          if (rx_byte != VERSION_BYTE) begin
            phase_nxt     = P_HUNT;
            res_vld       = 1'b1;
            res.frame_end = 1'b1;
            res.status    = ST_VERSION;
          end else begin
            sum_nxt       = sum_add;
            remaining_nxt = rem_dec;
            phase_nxt     = P_SEQ;
          end
        end
        P_SEQ: begin
          sum_nxt       = sum_add;
          remaining_nxt = rem_dec;
          seq_nxt       = rx_byte;
          phase_nxt     = P_MOD;
        end
        P_MOD: begin
          sum_nxt       = sum_add;
          remaining_nxt = rem_dec;
          mod_nxt       = rx_byte;
          phase_nxt     = P_CMD;
        end
        P_CMD: begin
          sum_nxt       = sum_add;
          remaining_nxt = rem_dec;
          cmd_nxt       = rx_byte;
          phase_nxt     = (rem_dec <= 16'd1) ? P_CHK : P_DATA;
        end
        P_DATA: begin
          sum_nxt          = sum_add;
          remaining_nxt    = rem_dec;
          if (rem_dec <= 16'd1) phase_nxt = P_CHK;
          res_vld          = 1'b1;
          res.payload_byte = rx_byte;
        end
        P_CHK: begin
          phase_nxt     = P_HUNT;
          remaining_nxt = 16'd0;
          res_vld       = 1'b1;
          res.frame_end = 1'b1;
          res.status    = (rx_byte == sum_r) ? ST_GOOD : ST_SUM_BAD;
        end
        default: begin
          phase_nxt = P_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_HUNT;
      remaining_r <= 16'd0;
      sum_r       <= 8'd0;
      seq_r       <= 8'd0;
      mod_r       <= 8'd0;
      cmd_r       <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      sum_r       <= sum_nxt;
      seq_r       <= seq_nxt;
      mod_r       <= mod_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

endmodule

>>> hw/rtl/sld_out_skid.sv
// two-entry output register with skid slot, registered ready toward the parser
`timescale 1ns / 1ps
module sld_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sld_pkg::result_t push_data,
  output logic             can_accept,
  output logic             out_vld,
  output sld_pkg::result_t out_data,
  input  logic             out_rdy
);
  import sld_pkg::*;

  logic    main_vld_r, main_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;

  assign can_accept = !skid_vld_r;
  assign out_vld    = main_vld_r;
  assign out_data   = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (!main_vld_r || out_rdy) begin
      // head slot frees up: refill from skid first, else from the new word
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        main_nxt     = push_data;
        main_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> hw/rtl/sync_length_checksum_deframer.sv
// top level of the sync/length/checksum frame parser
`timescale 1ns / 1ps
// usage
//   in_ch  : one received serial byte per word (rx_byte), valid/ready
//   out_ch : one result word per payload byte and one end word per started
//            frame; frame_end=0 carries payload_byte, frame_end=1 carries status
//   frame  : AA 55 len_lo len_hi 01 seq module command payload... checksum,
//            len counts version through checksum, checksum is the 8-bit sum
//            of version through the last payload byte
//   status : good, checksum mismatch, length short, length long, bad version;
//            the receiver drops the payload of a frame whose status is not good
// timing
//   path: a byte's result is formed combinationally and registered in the output stage
//   throughput: one byte per cycle while in_ch.ready is high
//   stall: results wait in a two-entry output stage; in_ch.ready drops only
//          once both entries hold words, and comes from a register
// reset
//   rst_n (sync, active low) returns the parser to sync hunting, clears the
//   held header bytes and empties the output stage
module sync_length_checksum_deframer #(
  parameter int FRAME_BUFFER_BYTES = sld_pkg::FRAME_BUFFER_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sld_in_if.sink    in_ch,
  sld_out_if.source out_ch
);
  import sld_pkg::*;

  logic    byte_acc;   // input word taken this cycle
  logic    res_vld;    // parser produced a result word
  result_t res;
  logic    can_accept;
  logic    out_vld;
  result_t out_data;

  assign in_ch.ready = can_accept;
  assign byte_acc    = in_ch.valid && can_accept;

  // state machine: header capture, length and version checks, running checksum
  sld_parser #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_acc),
    .rx_byte  (in_ch.rx_byte),
    .res_vld  (res_vld),
    .res      (res)
  );

  // result register plus skid slot decouples out_ch.ready from in_ch.ready
  sld_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_vld),
    .push_data  (res),
    .can_accept (can_accept),
    .out_vld    (out_vld),
    .out_data   (out_data),
    .out_rdy    (out_ch.ready)
  );

  assign out_ch.valid        = out_vld;
  assign out_ch.frame_end    = out_data.frame_end;
  assign out_ch.payload_byte = out_data.payload_byte;
  assign out_ch.seq_number   = out_data.seq_number;
  assign out_ch.module_id    = out_data.module_id;
  assign out_ch.command_id   = out_data.command_id;
  assign out_ch.status       = out_data.status;

`ifndef ASSERT_OFF
  // back-pressure toward the sender only when a word is actually stuck at the output
  a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled while output stage is empty");

  // payload words never carry a bad status
  a_payload_status_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.frame_end) |-> (out_ch.status == ST_GOOD))
    else $error("payload word with non-good status");

  // end words carry a zero payload field
  a_end_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> (out_ch.payload_byte == 8'd0))
    else $error("end word with nonzero payload byte");

  // output stage comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!out_ch.valid && in_ch.ready))
    else $error("output stage not empty after reset");
`endif

endmodule

>>> tb/tb_sync_length_checksum_deframer.sv
// self-checking testbench for the sync/length/checksum deframer
`timescale 1ns / 1ps
module tb_sync_length_checksum_deframer;
  import sld_pkg::*;

  localparam int BUF_BYTES   = FRAME_BUFFER_BYTES_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LIVE_BYTES  = 1550;

  // parser phases of the local frame model
  typedef enum logic [3:0] {
    PH_HUNT, PH_SYNC2, PH_LEN_LO, PH_LEN_HI, PH_VER,
    PH_SEQ, PH_MOD, PH_CMD, PH_DATA, PH_CHK
  } parse_phase_t;

  // one directed word: the byte, and a hand-written result word where one is pinned
  typedef struct {
    logic [7:0] rx;
    bit         pinned;
    result_t    want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       src_valid = 1'b0;
  logic [7:0] src_byte = 8'h00;
  logic       sink_ready = 1'b0;

  sld_in_if  in_ch ();
  sld_out_if out_ch ();

  assign in_ch.valid   = src_valid;
  assign in_ch.rx_byte = src_byte;
  assign out_ch.ready  = sink_ready;

  sync_length_checksum_deframer #(
    .FRAME_BUFFER_BYTES(BUF_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // frame model state
  parse_phase_t parse_phase = PH_HUNT;
  logic [15:0]  bytes_left = '0;
  logic [7:0]   sum_acc = '0;
  logic [7:0]   held_seq = '0;
  logic [7:0]   held_mod = '0;
  logic [7:0]   held_cmd = '0;

  result_t expected_words[$];
  int      mismatches = 0;
  int      words_seen = 0;
  int      live_bytes = 0;
  int      cycle_count = 0;
  int      recv_wait = 0;
  bit      pressure_done = 1'b0;
  result_t got_word;
  result_t want_word;

  // directed words: a good empty frame, a bad sync byte that is not rechecked,
  // then short, long and bad version headers
  stim_row_t directed_rows [24] = '{
    // empty payload, checksum follows the command byte directly
    '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'h05, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
    '{8'h80, 1'b1, result_t'{1'b1, 8'h00, 8'hFF, 8'h00, 8'h80, ST_GOOD}},
    // second AA drops to hunting, third AA starts a frame, length zero is short
    '{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, result_t'{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, ST_SHORT}},
    // largest length, too long for the buffer
    '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, result_t'{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, ST_LONG}},
    // wrong version byte
    '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'h06, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hFE, 1'b1, result_t'{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, ST_VERSION}}
  };

  // idle length: mostly none or short, a few long; calm stretches have none
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (((cycle_count / 3000) % 3) == 2) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t frame_word(input logic fe, input logic [7:0] pb,
                                         input logic [2:0] st);
    result_t w;
    w.frame_end    = fe;
    w.payload_byte = pb;
    w.seq_number   = held_seq;
    w.module_id    = held_mod;
    w.command_id   = held_cmd;
    w.status       = st;
    return w;
  endfunction

  // advance the frame model by one received byte; returns 1 when a word is due
  function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    case (parse_phase)
      PH_HUNT: begin
        if (b == SYNC_FIRST) parse_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          held_seq    = '0;
          held_mod    = '0;
          held_cmd    = '0;
          parse_phase = PH_LEN_LO;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        bytes_left  = {8'h00, b};
        parse_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        bytes_left[15:8] = b;
        sum_acc = '0;
        if (bytes_left < MIN_LENGTH) begin
          parse_phase = PH_HUNT;
          res = frame_word(1'b1, 8'h00, ST_SHORT);
          hit = 1'b1;
        end else if (int'(bytes_left) + PREFIX_BYTES > BUF_BYTES) begin
          parse_phase = PH_HUNT;
          res = frame_word(1'b1, 8'h00, ST_LONG);
          hit = 1'b1;
        end else begin
          parse_phase = PH_VER;
        end
      end
      PH_VER: begin
        if (b != VERSION_BYTE) begin
          parse_phase = PH_HUNT;
          res = frame_word(1'b1, 8'h00, ST_VERSION);
          hit = 1'b1;
        end else begin
          sum_acc     = sum_acc + b;
          bytes_left  = bytes_left - 16'd1;
          parse_phase = PH_SEQ;
        end
      end
      PH_SEQ, PH_MOD, PH_CMD: begin
        sum_acc    = sum_acc + b;
        bytes_left = bytes_left - 16'd1;
        if (parse_phase == PH_SEQ) begin
          held_seq    = b;
          parse_phase = PH_MOD;
        end else if (parse_phase == PH_MOD) begin
          held_mod    = b;
          parse_phase = PH_CMD;
        end else begin
          // an empty payload goes straight to the checksum byte
          held_cmd    = b;
          parse_phase = (bytes_left <= 16'd1) ? PH_CHK : PH_DATA;
        end
      end
      PH_DATA: begin
        sum_acc    = sum_acc + b;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left <= 16'd1) parse_phase = PH_CHK;
        res = frame_word(1'b0, b, ST_GOOD);
        hit = 1'b1;
      end
      PH_CHK: begin
        parse_phase = PH_HUNT;
        bytes_left  = '0;
        res = frame_word(1'b1, 8'h00, (b == sum_acc) ? ST_GOOD : ST_SUM_BAD);
        hit = 1'b1;
      end
      default: parse_phase = PH_HUNT;
    endcase
    return hit;
  endfunction

  // offer one byte, wait for it to be taken, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input bit pinned, input result_t pinned_word);
    int      gap;
    bit      has;
    result_t word;
    gap = pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_byte  <= b;
    do @(posedge clk); while (!in_ch.ready);
    // bytes dropped while hunting do not count as live stimulus
    if (parse_phase != PH_HUNT || b == SYNC_FIRST) live_bytes++;
    has = deframe_byte(b, word);
    if (pinned) expected_words.push_back(pinned_word);
    else if (has) expected_words.push_back(word);
  endtask

  task automatic send_header(input logic [15:0] len);
    send_byte(SYNC_FIRST, 1'b0, '0);
    send_byte(SYNC_SECOND, 1'b0, '0);
    send_byte(len[7:0], 1'b0, '0);
    send_byte(len[15:8], 1'b0, '0);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", name, got, want));
  endtask

  // stimulus: directed words first, then random frames with some broken ones
  initial begin : stimulus
    int          pick;
    int          flen;
    logic [7:0]  b;
    logic [7:0]  fsum;
    logic [15:0] len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].want);

    while (live_bytes < LIVE_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        // well-formed frame, mostly short, now and then near the buffer limit
        flen = $urandom_range(0, 99);
        if (flen < 80) flen = $urandom_range(5, 24);
        else if (flen < 96) flen = $urandom_range(25, 80);
        else flen = $urandom_range(200, BUF_BYTES - PREFIX_BYTES);
        send_header(16'(flen));
        send_byte(VERSION_BYTE, 1'b0, '0);
        fsum = VERSION_BYTE;
        for (int k = 0; k < flen - 2; k++) begin
          // sequence, module, command and payload bytes
          b = 8'($urandom_range(0, 255));
          fsum = fsum + b;
          send_byte(b, 1'b0, '0);
        end
        // one in ten checksums is corrupted
        if ($urandom_range(0, 9) == 0) fsum = fsum + 8'($urandom_range(1, 255));
        send_byte(fsum, 1'b0, '0);
      end else if (pick < 78) begin
        // sync pair broken in its second byte
        b = 8'($urandom_range(0, 254));
        if (b >= SYNC_SECOND) b = b + 8'd1;
        send_byte(SYNC_FIRST, 1'b0, '0);
        send_byte(b, 1'b0, '0);
      end else if (pick < 84) begin
        send_header(16'($urandom_range(0, 4)));
      end else if (pick < 90) begin
        len = 16'($urandom_range(BUF_BYTES - PREFIX_BYTES + 1, 65535));
        send_header(len);
      end else if (pick < 95) begin
        b = 8'($urandom_range(2, 256));
        send_header(16'($urandom_range(5, 24)));
        send_byte(b, 1'b0, '0);
      end else begin
        // line noise between frames
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    src_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    // the trailing wait after the last expected word catches any extra result words
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result receiver: random stalls, plus one long hold-off that fills the output stage
  always @(posedge clk) begin
    if (recv_wait > 0) begin
      sink_ready <= 1'b0;
      recv_wait  <= recv_wait - 1;
    end else if (!pressure_done && words_seen >= 300) begin
      pressure_done <= 1'b1;
      recv_wait     <= 400;
      sink_ready    <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
      recv_wait  <= pick_gap();
    end
  end

  // result checker: each taken word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && sink_ready) begin
      words_seen <= words_seen + 1;
      got_word.frame_end    = out_ch.frame_end;
      got_word.payload_byte = out_ch.payload_byte;
      got_word.seq_number   = out_ch.seq_number;
      got_word.module_id    = out_ch.module_id;
      got_word.command_id   = out_ch.command_id;
      got_word.status       = out_ch.status;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word 0x%09h with none expected", got_word));
      end else begin
        want_word = expected_words.pop_front();
        check_field("frame_end", 8'(got_word.frame_end), 8'(want_word.frame_end));
        check_field("payload_byte", got_word.payload_byte, want_word.payload_byte);
        check_field("seq_number", got_word.seq_number, want_word.seq_number);
        check_field("module_id", got_word.module_id, want_word.module_id);
        check_field("command_id", got_word.command_id, want_word.command_id);
        check_field("status", 8'(got_word.status), 8'(want_word.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

>>> sync_length_checksum_deframer.f
hw/rtl/sld_pkg.sv
hw/rtl/sld_if.sv
hw/rtl/sld_parser.sv
hw/rtl/sld_out_skid.sv
hw/rtl/sync_length_checksum_deframer.sv
tb/tb_sync_length_checksum_deframer.sv
